>>> hw/rtl/phfa_pkg.sv
// package for the page heap fit allocator: sizes, codes, fsm states and the
// page table entry layout; no dependencies
package phfa_pkg;

  localparam int HEAP_PAGES = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int PG_W       = $clog2(HEAP_PAGES);
  localparam int CNT_W      = $clog2(HEAP_PAGES + 1);
  localparam int SIZE_W     = 23;
  localparam int SUM_W      = SIZE_W + 1;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int ENTRY_W    = CNT_W + 1;

  localparam logic [CNT_W-1:0] TOP = CNT_W'(HEAP_PAGES);

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_NEXT  = 2'd1,
    STRAT_BEST  = 2'd2,
    STRAT_WORST = 2'd3
  } strategy_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_BAD   = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_PLACE,
    S_RESP
  } state_t;

  // one page table word: block start flag and exclusive end page
  typedef struct packed {
    logic             flag;
    logic [CNT_W-1:0] end_page;
  } entry_t;

endpackage

>>> hw/rtl/phfa_ram.sv
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
module phfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/page_heap_fit_allocator_core.sv
// page heap fit allocator top level: fsm walking the page table page by page and block by block
// depends on phfa_pkg and phfa_ram
//
//  port group  dir   handshake            word
//  in_*        in    in_valid/in_ready    action, size_bytes, block_page
//  out_*       out   out_valid/out_ready  status, start_page
//  cfg_*       in    cfg_valid/cfg_ready  strategy (2 bits)
//
// after reset a clearing pass writes every page table entry with in_ready low;
// cfg writes are taken at any time
// allocate: the scan reads one free page or one whole block at a time up to the
// heap top (a next fit search wraps to page 0 and its run from there may reach
// past the origin), paced by the single read port of the page table memory
// free: the entry is read, checked and cleared; a finished word waits in the
// output register while the next word is accepted, so out_ready low stalls
// only the following result
module page_heap_fit_allocator_core import phfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [SIZE_W-1:0] in_size_bytes,
  input  logic [PG_W-1:0]   in_block_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [PG_W-1:0]   out_start_page,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_wdata
);

  state_t           state_r, state_nxt;
  strategy_t        strategy_r;
  logic [CNT_W-1:0] next_fit_r, next_fit_nxt;
  logic [CNT_W-1:0] origin_r, origin_nxt;
  logic [CNT_W-1:0] pages_r, pages_nxt;
  logic [CNT_W-1:0] best_len_r, best_len_nxt;
  logic [PG_W-1:0]  pos_r, pos_nxt;
  logic [PG_W-1:0]  run_start_r, run_start_nxt;
  logic [PG_W-1:0]  best_start_r, best_start_nxt;
  logic [PG_W-1:0]  place_start_r, place_start_nxt;
  logic [PG_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [PG_W-1:0]  res_start_r, res_start_nxt;
  logic             in_run_r, in_run_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic             best_valid_r, best_valid_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [PG_W-1:0]  out_start_r, out_start_nxt;

  logic               mem_we, mem_re;
  logic [PG_W-1:0]    mem_waddr, mem_raddr;
  entry_t             mem_wdata, rd_entry;
  logic [ENTRY_W-1:0] mem_rdata;

  logic              in_fire;
  logic [SUM_W-1:0]  size_sum, pages_full;
  logic              size_zero, size_over;
  logic [CNT_W-1:0]  origin_sel;

  // scan decode
  logic [CNT_W-1:0] q_ext, q1, np, cand_end, cand_len;
  logic [PG_W-1:0]  cand_start, fin_start;
  logic             walk_pos, stop_here, cand_v, fits, hit, better;
  logic             at_top, wrap_go, any_best, is_next;
  logic [CNT_W-1:0] place_end;

  phfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_PAGES)
  ) u_page_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_entry = entry_t'(mem_rdata);

  assign in_ready       = (state_r == S_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_start_page = out_start_r;

  // round the byte size up to whole pages
  assign size_sum   = {1'b0, in_size_bytes} + SUM_W'(PAGE_BYTES - 1);
  assign pages_full = size_sum >> PAGE_SHIFT;
  assign size_zero  = (in_size_bytes == '0);
  assign size_over  = (pages_full > SUM_W'(HEAP_PAGES));
  assign origin_sel = (next_fit_r >= TOP) ? '0 : next_fit_r;
  assign is_next    = (strategy_r == STRAT_NEXT);
  assign place_end  = {1'b0, place_start_r} + pages_r;

  // one page or one whole block per cycle
  always_comb begin
    q_ext     = {1'b0, pos_r};
    q1        = q_ext + CNT_W'(1);
    walk_pos  = rd_entry.flag || !in_run_r;
    stop_here = is_next && wrapped_r && walk_pos && (q_ext >= origin_r);
    cand_v     = 1'b0;
    cand_start = run_start_r;
    cand_end   = q_ext;
    if (rd_entry.flag && in_run_r) begin
      cand_v = 1'b1;
    end else if (!rd_entry.flag && (q1 == TOP)) begin
      cand_v     = !stop_here;
      cand_start = in_run_r ? run_start_r : pos_r;
      cand_end   = TOP;
    end
    cand_len = cand_end - {1'b0, cand_start};
    fits     = cand_v && (cand_len >= pages_r);
    hit      = fits && ((strategy_r == STRAT_FIRST) || is_next);
    better   = fits && !hit &&
               (!best_valid_r ||
                ((strategy_r == STRAT_BEST) && (cand_len < best_len_r)) ||
                ((strategy_r == STRAT_WORST) && (cand_len > best_len_r)));
    if (rd_entry.flag) begin
      np = ((rd_entry.end_page <= q_ext) || (rd_entry.end_page > TOP)) ? q1
                                                                      : rd_entry.end_page;
    end else begin
      np = q1;
    end
    at_top    = (np == TOP);
    wrap_go   = at_top && is_next && !wrapped_r;
    any_best  = best_valid_r || better;
    fin_start = better ? cand_start : best_start_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == PG_W'(HEAP_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (action_t'(in_action) == ACT_FREE) begin
            state_nxt = S_FREE;
          end else if (size_zero || size_over) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_PLACE;
        end else if (stop_here) begin
          state_nxt = S_RESP;
        end else if (at_top) begin
          if (wrap_go) begin
            state_nxt = (origin_r == '0) ? S_RESP : S_SCAN;
          end else begin
            state_nxt = any_best ? S_PLACE : S_RESP;
          end
        end
      end
      S_FREE:  state_nxt = S_RESP;
      S_PLACE: state_nxt = S_RESP;
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    next_fit_nxt    = next_fit_r;
    origin_nxt      = origin_r;
    pages_nxt       = pages_r;
    best_len_nxt    = best_len_r;
    pos_nxt         = pos_r;
    run_start_nxt   = run_start_r;
    best_start_nxt  = best_start_r;
    place_start_nxt = place_start_r;
    clr_cnt_nxt     = clr_cnt_r;
    res_start_nxt   = res_start_r;
    in_run_nxt      = in_run_r;
    wrapped_nxt     = wrapped_r;
    best_valid_nxt  = best_valid_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_start_nxt   = out_start_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + PG_W'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          mem_re         = 1'b1;
          mem_raddr      = (action_t'(in_action) == ACT_FREE) ? in_block_page
                           : (is_next ? origin_sel[PG_W-1:0] : '0);
          pos_nxt        = mem_raddr;
          pages_nxt      = pages_full[CNT_W-1:0];
          origin_nxt     = origin_sel;
          in_run_nxt     = 1'b0;
          wrapped_nxt    = 1'b0;
          best_valid_nxt = 1'b0;
          res_start_nxt  = '0;
          res_status_nxt = size_zero ? STAT_BAD : (size_over ? STAT_NOFIT : STAT_DONE);
        end
      end
      S_SCAN: begin
        if (better) begin
          best_valid_nxt = 1'b1;
          best_start_nxt = cand_start;
          best_len_nxt   = cand_len;
        end
        if (hit) begin
          place_start_nxt = cand_start;
        end else if (stop_here) begin
          res_status_nxt = STAT_NOFIT;
        end else if (at_top) begin
          if (wrap_go) begin
            // second pass from page 0 back up to the origin
            mem_re      = 1'b1;
            mem_raddr   = '0;
            pos_nxt     = '0;
            wrapped_nxt = 1'b1;
            in_run_nxt  = 1'b0;
            if (origin_r == '0) begin
              res_status_nxt = STAT_NOFIT;
            end
          end else begin
            place_start_nxt = fin_start;
            if (!any_best) begin
              res_status_nxt = STAT_NOFIT;
            end
          end
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = np[PG_W-1:0];
          pos_nxt    = np[PG_W-1:0];
          in_run_nxt = !rd_entry.flag;
          if (!rd_entry.flag && !in_run_r) begin
            run_start_nxt = pos_r;
          end
        end
      end
      S_FREE: begin
        if (rd_entry.flag && ({1'b0, pos_r} < TOP)) begin
          mem_we         = 1'b1;
          mem_waddr      = pos_r;
          res_status_nxt = STAT_DONE;
        end else begin
          res_status_nxt = STAT_BAD;
        end
      end
      S_PLACE: begin
        mem_we             = 1'b1;
        mem_waddr          = place_start_r;
        mem_wdata.flag     = 1'b1;
        mem_wdata.end_page = place_end;
        if (is_next) begin
          next_fit_nxt = place_end;
        end
        res_status_nxt = STAT_DONE;
        res_start_nxt  = place_start_r;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      next_fit_r  <= '0;
      strategy_r  <= STRAT_FIRST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      next_fit_r  <= next_fit_nxt;
      if (cfg_valid && cfg_ready) begin
        strategy_r <= strategy_t'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    origin_r      <= origin_nxt;
    pages_r       <= pages_nxt;
    best_len_r    <= best_len_nxt;
    pos_r         <= pos_nxt;
    run_start_r   <= run_start_nxt;
    best_start_r  <= best_start_nxt;
    place_start_r <= place_start_nxt;
    res_start_r   <= res_start_nxt;
    in_run_r      <= in_run_nxt;
    wrapped_r     <= wrapped_nxt;
    best_valid_r  <= best_valid_nxt;
    res_status_r  <= res_status_nxt;
    out_status_r  <= out_status_nxt;
    out_start_r   <= out_start_nxt;
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready)
    else $error("word accepted during page table clearing pass");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !mem_we)
    else $error("page table written during scan");

  a_place_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PLACE |-> (place_end <= TOP) && (pages_r != '0))
    else $error("placed block runs past heap top");

  a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != STAT_DONE) |-> out_start_r == '0)
    else $error("failed result carries a start page");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

endmodule
